@@ sv/ordal_pkg.sv @@
// ============================================================================
// ordal_pkg
// shared types and codes for the ordered array list engine
// ============================================================================
package ordal_pkg;

    localparam int KIND_W   = 3;
    localparam int POS_W    = 9;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 3'd0,
        KIND_DELETE = 3'd1,
        KIND_GET    = 3'd2,
        KIND_LOCATE = 3'd3,
        KIND_CLEAR  = 3'd4
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_BADPOS   = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INSERT,
        S_PUT,
        S_DELETE,
        S_GET,
        S_SCAN,
        S_DONE
    } state_t;

    typedef struct packed {
        status_t            status;
        logic [VALUE_W-1:0] read_value;
        logic [POS_W-1:0]   found_position;
        logic [POS_W-1:0]   length;
        logic               is_empty;
    } result_t;

endpackage

@@ sv/ordal_mem.sv @@
// ============================================================================
// ordal_mem
// entry storage, one write port and one registered read port
// ============================================================================
module ordal_mem #(
    parameter int DEPTH      = 256,
    parameter int DATA_WIDTH = 32,
    parameter int AW         = 8
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  logic [DATA_WIDTH-1:0] wr_data,
    input  logic [AW-1:0]         rd_addr,
    output logic [DATA_WIDTH-1:0] rd_data
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

@@ sv/ordal_ctrl.sv @@
// ============================================================================
// ordal_ctrl
// operation sequencer: checks, entry count, shift and scan walk over memory
// ============================================================================
module ordal_ctrl #(
    parameter int DEPTH      = 256,
    parameter int DATA_WIDTH = 32,
    parameter int AW         = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          busy,
    input  logic [ordal_pkg::KIND_W-1:0]  kind,
    input  logic [ordal_pkg::POS_W-1:0]   position,
    input  logic [ordal_pkg::VALUE_W-1:0] item_value,
    input  logic                          slot_free,
    output logic                          push,
    output ordal_pkg::result_t            result,
    output logic                          wr_en,
    output logic [AW-1:0]                 wr_addr,
    output logic [DATA_WIDTH-1:0]         wr_data,
    output logic [AW-1:0]                 rd_addr,
    input  logic [DATA_WIDTH-1:0]         rd_data
);

    import ordal_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = ((CW > POS_W) ? CW : POS_W) + 1;

    state_t                state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [AW-1:0]         idx_reg, idx_next;
    logic                  first_reg, first_next;
    logic [AW-1:0]         pidx_reg, pidx_next;
    logic [DATA_WIDTH-1:0] val_reg, val_next;
    status_t               status_reg, status_next;
    logic [DATA_WIDTH-1:0] read_reg, read_next;
    logic [POS_W-1:0]      found_reg, found_next;

    logic [EW-1:0]         pos_e;
    logic [EW-1:0]         cnt_e;
    logic [EW-1:0]         pos_m1;
    logic [AW-1:0]         pidx_in;
    logic [DATA_WIDTH-1:0] val_in;
    logic [CW-1:0]         cnt_dec;
    logic [AW-1:0]         cnt_m1;
    logic [AW:0]           idx_inc;
    logic                  is_full;
    logic                  is_zero;
    logic                  bad_ins;
    logic                  bad_pos;

    assign pos_e   = EW'(position);
    assign cnt_e   = EW'(count_reg);
    assign pos_m1  = pos_e - EW'(1);
    assign pidx_in = pos_m1[AW-1:0];
    assign val_in  = DATA_WIDTH'(item_value);
    assign cnt_dec = count_reg - CW'(1);
    assign cnt_m1  = cnt_dec[AW-1:0];
    assign idx_inc = {1'b0, idx_reg} + (AW+1)'(1);
    assign is_full = (count_reg == CW'(DEPTH));
    assign is_zero = (count_reg == '0);
    assign bad_ins = (pos_e == '0) || (pos_e > cnt_e + EW'(1));
    assign bad_pos = (pos_e == '0) || (pos_e > cnt_e);

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        result.status         = status_reg;
        result.read_value     = VALUE_W'(read_reg);
        result.found_position = found_reg;
        result.length         = POS_W'(count_reg);
        result.is_empty       = is_zero;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            first_reg <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        pidx_reg   <= pidx_next;
        val_reg    <= val_next;
        status_reg <= status_next;
        read_reg   <= read_next;
        found_reg  <= found_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        first_next  = first_reg;
        pidx_next   = pidx_reg;
        val_next    = val_reg;
        status_next = status_reg;
        read_next   = read_reg;
        found_next  = found_reg;
        rd_addr     = idx_reg;
        wr_en       = 1'b0;
        wr_addr     = idx_reg;
        wr_data     = rd_data;
        push        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    val_next    = val_in;
                    pidx_next   = pidx_in;
                    read_next   = '0;
                    found_next  = '0;
                    status_next = ST_OK;
                    state_next  = S_DONE;
                    case (kind)
                        KIND_INSERT:
                        begin
                            if (is_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else if (bad_ins)
                            begin
                                status_next = ST_BADPOS;
                            end
                            else if (pos_e == cnt_e + EW'(1))
                            begin
                                // append at the tail, no shift
                                wr_en      = 1'b1;
                                wr_addr    = pidx_in;
                                wr_data    = val_in;
                                count_next = count_reg + CW'(1);
                            end
                            else
                            begin
                                rd_addr    = cnt_m1;
                                idx_next   = cnt_m1;
                                state_next = S_INSERT;
                            end
                        end
                        KIND_DELETE:
                        begin
                            if (is_zero)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else if (bad_pos)
                            begin
                                status_next = ST_BADPOS;
                            end
                            else
                            begin
                                rd_addr    = pidx_in;
                                idx_next   = pidx_in;
                                first_next = 1'b1;
                                state_next = S_DELETE;
                            end
                        end
                        KIND_GET:
                        begin
                            if (bad_pos)
                            begin
                                status_next = ST_BADPOS;
                            end
                            else
                            begin
                                rd_addr    = pidx_in;
                                idx_next   = pidx_in;
                                state_next = S_GET;
                            end
                        end
                        KIND_LOCATE:
                        begin
                            if (is_zero)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                rd_addr    = '0;
                                idx_next   = '0;
                                state_next = S_SCAN;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_INSERT:
            begin
                // move entry up one place while fetching the one below
                wr_en   = 1'b1;
                wr_addr = idx_inc[AW-1:0];
                wr_data = rd_data;
                if (idx_reg == pidx_reg)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    rd_addr  = idx_reg - AW'(1);
                    idx_next = idx_reg - AW'(1);
                end
            end
            S_PUT:
            begin
                wr_en      = 1'b1;
                wr_addr    = pidx_reg;
                wr_data    = val_reg;
                count_next = count_reg + CW'(1);
                state_next = S_DONE;
            end
            S_DELETE:
            begin
                if (first_reg)
                begin
                    read_next  = rd_data;
                    first_next = 1'b0;
                end
                else
                begin
                    wr_en   = 1'b1;
                    wr_addr = idx_reg - AW'(1);
                    wr_data = rd_data;
                end
                if (idx_reg == cnt_m1)
                begin
                    count_next = cnt_dec;
                    state_next = S_DONE;
                end
                else
                begin
                    rd_addr  = idx_inc[AW-1:0];
                    idx_next = idx_inc[AW-1:0];
                end
            end
            S_GET:
            begin
                read_next  = rd_data;
                state_next = S_DONE;
            end
            S_SCAN:
            begin
                if (rd_data == val_reg)
                begin
                    found_next  = POS_W'(idx_inc);
                    status_next = ST_OK;
                    state_next  = S_DONE;
                end
                else if (idx_reg == cnt_m1)
                begin
                    status_next = ST_NOTFOUND;
                    state_next  = S_DONE;
                end
                else
                begin
                    rd_addr  = idx_inc[AW-1:0];
                    idx_next = idx_inc[AW-1:0];
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    push       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ sv/ordered_array_list_engine.sv @@
// ============================================================================
// ordered_array_list_engine
// fixed-capacity ordered list with insert, delete, get, locate and clear
// ============================================================================
//  channel  handshake            payload
//  req      req_valid/req_stall  kind, position, item_value
//  rsp      rsp_valid/rsp_stall  status, read_value, found_position,
//                                length, is_empty
//
//  one request in flight; insert shifts entries up one place from the tail,
//  delete moves later entries down one place, locate compares from the first
//  entry; these walks step through memory by the single memory read port
//  rst_n clears the count and control; entry contents need no reset
//  a result waits in the output register while rsp_stall is high
// ============================================================================
module ordered_array_list_engine #(
    parameter int DEPTH      = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  logic [ordal_pkg::KIND_W-1:0]   kind,
    input  logic [ordal_pkg::POS_W-1:0]    position,
    input  logic [ordal_pkg::VALUE_W-1:0]  item_value,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output logic [ordal_pkg::STATUS_W-1:0] status,
    output logic [ordal_pkg::VALUE_W-1:0]  read_value,
    output logic [ordal_pkg::POS_W-1:0]    found_position,
    output logic [ordal_pkg::POS_W-1:0]    length,
    output logic                           is_empty
);

    import ordal_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                  busy;
    logic                  push;
    logic                  slot_free;
    result_t               result;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [AW-1:0]         rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;

    logic                  rsp_valid_reg, rsp_valid_next;
    result_t               rsp_reg, rsp_next;

    assign req_stall = busy;
    assign slot_free = !rsp_valid_reg || !rsp_stall;

    ordal_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .busy       (busy),
        .kind       (kind),
        .position   (position),
        .item_value (item_value),
        .slot_free  (slot_free),
        .push       (push),
        .result     (result),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data)
    );

    ordal_mem #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW)
    ) u_mem (
        .clk        (clk),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data)
    );

    // output transaction register
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (push)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = result;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid      = rsp_valid_reg;
    assign status         = rsp_reg.status;
    assign read_value     = rsp_reg.read_value;
    assign found_position = rsp_reg.found_position;
    assign length         = rsp_reg.length;
    assign is_empty       = rsp_reg.is_empty;

endmodule

@@ dv/tb.sv @@
// ============================================================================
// tb
// Self-checking testbench for the ordered array list engine. A queue-based
// list model predicts each result from the accepted requests. The run is a
// short directed pass over the edge cases, then fill-to-full, drain-to-empty
// and mixed random traffic. Random request gaps and response stalls are
// applied throughout.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ordal_pkg::*;

    localparam int LIST_DEPTH    = 256;
    localparam int POS_MAX       = (1 << POS_W) - 1;
    localparam int MAX_WAIT      = 16;
    localparam int SETTLE_CYCLES = 300;
    localparam int QUIET_LIMIT   = 4000;
    localparam int PRINT_LIMIT   = 100;

    localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

    logic                clk;
    logic                rst_n;
    logic                req_valid;
    logic                req_stall;
    logic [KIND_W-1:0]   kind;
    logic [POS_W-1:0]    position;
    logic [VALUE_W-1:0]  item_value;
    logic                rsp_valid;
    logic                rsp_stall;
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  read_value;
    logic [POS_W-1:0]    found_position;
    logic [POS_W-1:0]    length;
    logic                is_empty;

    logic [VALUE_W-1:0] list_words[$];
    result_t            pending_results[$];
    int                 error_count  = 0;
    int                 quiet_cycles = 0;
    bit                 req_calm     = 1'b0;
    bit                 rsp_calm     = 1'b0;

    ordered_array_list_engine u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .kind           (kind),
        .position       (position),
        .item_value     (item_value),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .status         (status),
        .read_value     (read_value),
        .found_position (found_position),
        .length         (length),
        .is_empty       (is_empty)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // idle draw, with occasional runs of back-to-back traffic
    function automatic int draw_wait(inout bit calm);
        if ($urandom_range(0, 39) == 0)
            calm = !calm;
        return calm ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic result_t predict_list_op(logic [KIND_W-1:0] op,
                                                logic [POS_W-1:0] pos,
                                                logic [VALUE_W-1:0] word);
        result_t r;
        int      n;
        n = list_words.size();
        r.status         = ST_OK;
        r.read_value     = '0;
        r.found_position = '0;
        case (op)
            KIND_INSERT:
            begin
                if (n >= LIST_DEPTH)
                    r.status = ST_FULL;
                else if (pos == 0 || pos > n + 1)
                    r.status = ST_BADPOS;
                else
                    list_words.insert(pos - 1, word);
            end
            KIND_DELETE:
            begin
                if (n == 0)
                    r.status = ST_EMPTY;
                else if (pos == 0 || pos > n)
                    r.status = ST_BADPOS;
                else
                begin
                    r.read_value = list_words[pos - 1];
                    list_words.delete(pos - 1);
                end
            end
            KIND_GET:
            begin
                if (pos == 0 || pos > n)
                    r.status = ST_BADPOS;
                else
                    r.read_value = list_words[pos - 1];
            end
            KIND_LOCATE:
            begin
                if (n == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.status = ST_NOTFOUND;
                    for (int k = 0; k < n; k++)
                    begin
                        if (list_words[k] == word)
                        begin
                            r.found_position = POS_W'(k + 1);
                            r.status         = ST_OK;
                            break;
                        end
                    end
                end
            end
            KIND_CLEAR:
                list_words.delete();
            default:
                ;
        endcase
        r.length   = POS_W'(list_words.size());
        r.is_empty = (list_words.size() == 0);
        return r;
    endfunction

    task automatic report_error(string msg);
        if (error_count < PRINT_LIMIT)
            $display("tb: mismatch: %s", msg);
        error_count++;
    endtask

    task automatic check_field(string name, logic [VALUE_W-1:0] got,
                               logic [VALUE_W-1:0] want);
        if (got !== want)
            report_error($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    task automatic send_request(logic [KIND_W-1:0] op, int pos,
                                logic [VALUE_W-1:0] word);
        int gap;
        gap = draw_wait(req_calm);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid  <= 1'b1;
        kind       <= op;
        position   <= POS_W'(pos);
        item_value <= word;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        pending_results.push_back(predict_list_op(op, POS_W'(pos), word));
    endtask

    // mostly a legal position, otherwise anywhere in the field
    function automatic int some_pos(int hi);
        if (hi > 0 && $urandom_range(0, 9) < 8)
            return $urandom_range(1, hi);
        return $urandom_range(0, POS_MAX);
    endfunction

    function automatic int out_of_range(int hi);
        if ($urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(hi + 1, POS_MAX);
    endfunction

    // a stored word more often than not, so locate hits
    function automatic logic [VALUE_W-1:0] search_word();
        if (list_words.size() > 0 && $urandom_range(0, 9) < 6)
            return list_words[$urandom_range(0, list_words.size() - 1)];
        return $urandom();
    endfunction

    task automatic test_empty_list();
        send_request(KIND_DELETE, 1, '0);
        send_request(KIND_GET, 0, '0);
        send_request(KIND_GET, 1, '0);
        send_request(KIND_LOCATE, 0, '1);
    endtask

    task automatic test_insert_bounds();
        send_request(KIND_INSERT, 0, 32'h0000_0001);
        send_request(KIND_INSERT, 2, 32'h0000_0002);
        send_request(KIND_INSERT, 1, '0);
        send_request(KIND_INSERT, 2, '1);
        send_request(KIND_INSERT, 1, 32'h5a5a_a5a5);
        send_request(KIND_INSERT, 5, 32'h0000_0003);
        send_request(KIND_INSERT, POS_MAX, 32'h0000_0004);
    endtask

    task automatic test_read_back();
        send_request(KIND_GET, 1, '0);
        send_request(KIND_GET, 3, '0);
        send_request(KIND_GET, 4, '0);
        send_request(KIND_GET, POS_MAX, '0);
        send_request(KIND_LOCATE, 0, '1);
        send_request(KIND_LOCATE, 0, 32'h1234_5678);
    endtask

    task automatic test_delete_bounds();
        send_request(KIND_DELETE, 0, '0);
        send_request(KIND_DELETE, 4, '0);
        send_request(KIND_DELETE, 2, '0);
    endtask

    task automatic test_spare_kinds();
        for (int k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++)
            send_request(KIND_W'(k), $urandom_range(0, POS_MAX), $urandom());
    endtask

    task automatic test_clear();
        send_request(KIND_CLEAR, 1, '1);
        send_request(KIND_GET, 1, '0);
    endtask

    task automatic test_fill_to_full();
        int n;
        while (list_words.size() < LIST_DEPTH)
        begin
            n = list_words.size();
            case ($urandom_range(0, 9))
                0: send_request(KIND_GET, some_pos(n), $urandom());
                1: send_request(KIND_LOCATE, $urandom_range(0, POS_MAX), search_word());
                2: send_request(KIND_INSERT, out_of_range(n + 1), $urandom());
                3: send_request(KIND_INSERT, $urandom_range(1, n + 1), search_word());
                default: send_request(KIND_INSERT, $urandom_range(1, n + 1), $urandom());
            endcase
        end
        // full list: fullness wins over a bad position
        send_request(KIND_INSERT, $urandom_range(1, LIST_DEPTH + 1), $urandom());
        send_request(KIND_INSERT, 0, $urandom());
        send_request(KIND_INSERT, POS_MAX, $urandom());
        send_request(KIND_GET, LIST_DEPTH, '0);
        send_request(KIND_GET, LIST_DEPTH + 1, '0);
        send_request(KIND_LOCATE, 0, list_words[LIST_DEPTH - 1]);
        send_request(KIND_LOCATE, 0, $urandom());
    endtask

    task automatic test_drain_to_empty();
        int n;
        while (list_words.size() > 0)
        begin
            n = list_words.size();
            case ($urandom_range(0, 9))
                0: send_request(KIND_GET, some_pos(n), $urandom());
                1: send_request(KIND_LOCATE, $urandom_range(0, POS_MAX), search_word());
                2: send_request(KIND_DELETE, out_of_range(n), $urandom());
                default: send_request(KIND_DELETE, $urandom_range(1, n), $urandom());
            endcase
        end
        send_request(KIND_DELETE, $urandom_range(0, POS_MAX), $urandom());
        send_request(KIND_LOCATE, 0, $urandom());
        send_request(KIND_GET, 0, $urandom());
    endtask

    task automatic test_random_mix(int count);
        int n;
        int pick;
        repeat (count)
        begin
            n    = list_words.size();
            pick = $urandom_range(0, 99);
            if (pick < 30)
                send_request(KIND_INSERT, some_pos(n + 1), $urandom());
            else if (pick < 55)
                send_request(KIND_DELETE, some_pos(n), $urandom());
            else if (pick < 75)
                send_request(KIND_GET, some_pos(n), $urandom());
            else if (pick < 91)
                send_request(KIND_LOCATE, $urandom_range(0, POS_MAX), search_word());
            else if (pick < 92)
                send_request(KIND_CLEAR, $urandom_range(0, POS_MAX), $urandom());
            else if (pick < 95)
                send_request(KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST)),
                             $urandom_range(0, POS_MAX), $urandom());
            else
                send_request(KIND_W'($urandom_range(0, (1 << KIND_W) - 1)),
                             $urandom_range(0, POS_MAX), $urandom());
        end
    endtask

    // response side: stall draw and result check
    initial
    begin : rsp_side
        int      hold;
        result_t want;
        hold = 0;
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_results.size() == 0)
                    report_error("result transaction with nothing pending");
                else
                begin
                    want = pending_results.pop_front();
                    check_field("status", VALUE_W'(status), VALUE_W'(want.status));
                    check_field("read_value", read_value, want.read_value);
                    check_field("found_position", VALUE_W'(found_position),
                                VALUE_W'(want.found_position));
                    check_field("length", VALUE_W'(length), VALUE_W'(want.length));
                    check_field("is_empty", VALUE_W'(is_empty), VALUE_W'(want.is_empty));
                end
                hold = draw_wait(rsp_calm);
            end
            else if (hold > 0)
                hold--;
            rsp_stall <= (hold > 0);
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n      <= 1'b0;
        req_valid  <= 1'b0;
        kind       <= KIND_CLEAR;
        position   <= '0;
        item_value <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_list();
        test_insert_bounds();
        test_read_back();
        test_delete_bounds();
        test_spare_kinds();
        test_clear();

        test_fill_to_full();
        test_random_mix(360);
        test_drain_to_empty();
        test_random_mix(360);
        test_fill_to_full();
        test_clear();
        test_random_mix(360);

        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

@@ ordered_array_list_engine.f @@
sv/ordal_pkg.sv
sv/ordal_mem.sv
sv/ordal_ctrl.sv
sv/ordered_array_list_engine.sv
dv/tb.sv
